// File: rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and saturating helpers for the mass-spring-damper
// energy step block.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

  // Number format: signed fixed point, Q16.32 at these values
  localparam int WordBits   = 48;
  localparam int FracBits   = 32;
  localparam int RegBits    = 47;
  localparam int CfgIdxBits = 3;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [RegBits-1:0]         creg_t;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_MASS      = 3'd0,
    REG_INV_MASS  = 3'd1,
    REG_DAMPING   = 3'd2,
    REG_STIFFNESS = 3'd3,
    REG_TIME_STEP = 3'd4
  } reg_idx_e;

  // Reset values: 1.5, 1/1.5, 0.8, 12.0 and 1e-4
  localparam creg_t MassRst      = 47'd6442450944;
  localparam creg_t InvMassRst   = 47'd2863311531;
  localparam creg_t DampingRst   = 47'd3435973837;
  localparam creg_t StiffnessRst = 47'd51539607552;
  localparam creg_t TimeStepRst  = 47'd429497;

  typedef struct packed {
    creg_t mass;
    creg_t inv_mass;
    creg_t damping;
    creg_t stiffness;
    creg_t time_step;
  } cfg_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } mul_req_t;

  // Unsigned register value as a non-negative word
  function automatic word_t to_word(creg_t c);
    return word_t'({1'b0, c});
  endfunction

  // a + b, clamped to the word range
  function automatic word_t sat_add(word_t a, word_t b);
    logic [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) begin
      return s[WordBits] ? WordMin : WordMax;
    end
    return word_t'(s[WordBits-1:0]);
  endfunction

  // a - b, clamped to the word range
  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WordBits:0] s;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) begin
      return s[WordBits] ? WordMin : WordMax;
    end
    return word_t'(s[WordBits-1:0]);
  endfunction

  // a / 2, truncated toward zero
  function automatic word_t halve(word_t a);
    logic [WordBits-1:0] t;
    t = a + {{(WordBits-1){1'b0}}, a[WordBits-1]};
    return word_t'({t[WordBits-1], t[WordBits-1:1]});
  endfunction

endpackage

`default_nettype wire

// File: rtl/msd_cfg.sv
// ----------------------------------------------------------------------------
// msd_cfg
// Configuration register file: mass, inverse mass, damping, stiffness and
// time step, written through a plain index/data port.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msd_pkg::CfgIdxBits-1:0]  cfg_addr_i,
  input  logic [msd_pkg::RegBits-1:0]     cfg_wdata_i,
  output msd_pkg::cfg_t                   cfg_o
);
  import msd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MASS:      cfg_d.mass      = cfg_wdata_i;
        REG_INV_MASS:  cfg_d.inv_mass  = cfg_wdata_i;
        REG_DAMPING:   cfg_d.damping   = cfg_wdata_i;
        REG_STIFFNESS: cfg_d.stiffness = cfg_wdata_i;
        REG_TIME_STEP: cfg_d.time_step = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mass      <= MassRst;
      cfg_q.inv_mass  <= InvMassRst;
      cfg_q.damping   <= DampingRst;
      cfg_q.stiffness <= StiffnessRst;
      cfg_q.time_step <= TimeStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/msd_mul.sv
// ----------------------------------------------------------------------------
// msd_mul
// Shared fixed-point multiplier. Sign and magnitude, four half-word partial
// products accumulated over successive cycles, then shift by the fraction
// width and clamp to the word range.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msd_pkg::mul_req_t req_i,
  output logic              done_o,
  output msd_pkg::word_t    prod_o
);
  import msd_pkg::*;

  localparam int HalfBits = WordBits / 2;
  localparam int ProdBits = 2 * WordBits;
  localparam logic [2:0] NumPp = 3'd4;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_SAT  = 3'b100
  } mul_state_e;

  mul_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       done_q, done_d;

  logic [WordBits-1:0] a_mag_q, a_mag_d, b_mag_q, b_mag_d;
  logic                neg_q, neg_d;
  logic [WordBits-1:0] pp_q, pp_d;
  logic [1:0]          sh_q, sh_d;
  logic [ProdBits-1:0] acc_q, acc_d;
  word_t               prod_q, prod_d;

  logic [HalfBits-1:0] a_half, b_half;
  logic [WordBits-1:0] pp_next;
  logic [ProdBits-1:0] pp_shifted;
  logic                over;
  logic [WordBits-2:0] mag;

  function automatic logic [WordBits-1:0] mag_of(word_t v);
    logic [WordBits-1:0] u;
    u = v;
    return v[WordBits-1] ? (~u + {{(WordBits-1){1'b0}}, 1'b1}) : u;
  endfunction

  // Half-word selection and product for the current partial product
  always_comb begin
    a_half  = cnt_q[1] ? a_mag_q[WordBits-1:HalfBits] : a_mag_q[HalfBits-1:0];
    b_half  = cnt_q[0] ? b_mag_q[WordBits-1:HalfBits] : b_mag_q[HalfBits-1:0];
    pp_next = {{HalfBits{1'b0}}, a_half} * {{HalfBits{1'b0}}, b_half};
  end

  // Align the registered partial product
  always_comb begin
    case (sh_q)
      2'd0:    pp_shifted = {{WordBits{1'b0}}, pp_q};
      2'd1:    pp_shifted = {{HalfBits{1'b0}}, pp_q, {HalfBits{1'b0}}};
      default: pp_shifted = {pp_q, {WordBits{1'b0}}};
    endcase
  end

  // Drop the fraction bits; anything above the word magnitude saturates
  assign over = |acc_q[ProdBits-1:WordBits-1+FracBits];
  assign mag  = acc_q[WordBits-2+FracBits:FracBits];

  // Sequencing of the partial products
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_mag_d = a_mag_q;
    b_mag_d = b_mag_q;
    neg_d   = neg_q;
    pp_d    = pp_q;
    sh_d    = sh_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_mag_d = mag_of(req_i.op_a);
          b_mag_d = mag_of(req_i.op_b);
          neg_d   = req_i.op_a[WordBits-1] ^ req_i.op_b[WordBits-1];
          acc_d   = '0;
          cnt_d   = '0;
          state_d = M_RUN;
        end
      end
      M_RUN: begin
        if (cnt_q != NumPp) begin
          pp_d = pp_next;
          sh_d = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
        end
        if (cnt_q != 3'd0) begin
          acc_d = acc_q + pp_shifted;
        end
        if (cnt_q == NumPp) begin
          state_d = M_SAT;
        end
        cnt_d = cnt_q + 3'd1;
      end
      M_SAT: begin
        if (over) begin
          prod_d = neg_q ? WordMin : WordMax;
        end else begin
          prod_d = neg_q ? word_t'(-{1'b0, mag}) : word_t'({1'b0, mag});
        end
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mag_q <= a_mag_d;
    b_mag_q <= b_mag_d;
    neg_q   <= neg_d;
    pp_q    <= pp_d;
    sh_q    <= sh_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: rtl/msd_ctrl.sv
// ----------------------------------------------------------------------------
// msd_ctrl
// Step sequencer and datapath registers. Walks one force beat through the
// energy audit and the Euler update, issuing each product to the shared
// multiplier, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  msd_pkg::word_t    force_req_i,
  input  logic              restart_i,
  input  msd_pkg::cfg_t     cfg_i,
  output msd_pkg::mul_req_t mul_req_o,
  input  logic              mul_done_i,
  input  msd_pkg::word_t    mul_prod_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output msd_pkg::word_t    position_o,
  output msd_pkg::word_t    velocity_o,
  output msd_pkg::word_t    power_in_o,
  output msd_pkg::word_t    power_lost_o,
  output msd_pkg::word_t    stored_energy_o,
  output msd_pkg::word_t    balance_residual_o
);
  import msd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  // Work steps, in order
  typedef enum logic [3:0] {
    ST_VV    = 4'd0,
    ST_PIN   = 4'd1,
    ST_PLOST = 4'd2,
    ST_E1    = 4'd3,
    ST_XX    = 4'd4,
    ST_E2    = 4'd5,
    ST_TSUM  = 4'd6,
    ST_TRAP  = 4'd7,
    ST_RESID = 4'd8,
    ST_CV    = 4'd9,
    ST_KX    = 4'd10,
    ST_ACC   = 4'd11,
    ST_DV    = 4'd12,
    ST_DX    = 4'd13
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;

  // Architectural state
  word_t pos_q, pos_d, vel_q, vel_d, prev_q, prev_d, work_q, work_d;
  logic  first_q, first_d;

  // Working registers
  word_t f_q, f_d, vv_q, vv_d, pin_q, pin_d, plost_q, plost_d;
  word_t ehalf_q, ehalf_d, energy_q, energy_d, net_q, net_d;
  word_t tsum_q, tsum_d, resid_q, resid_d, tmp_q, tmp_d;
  word_t npos_q, npos_d, nvel_q, nvel_d;

  // Output register
  word_t o_pos_q, o_pos_d, o_vel_q, o_vel_d, o_pin_q, o_pin_d;
  word_t o_plost_q, o_plost_d, o_energy_q, o_energy_d, o_resid_q, o_resid_d;

  logic mul_start;
  word_t op_a, op_b;

  // Operand selection for each multiply step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      ST_VV:    begin op_a = vel_q;                   op_b = vel_q;                   end
      ST_PIN:   begin op_a = f_q;                     op_b = vel_q;                   end
      ST_PLOST: begin op_a = to_word(cfg_i.damping);  op_b = vv_q;                    end
      ST_E1:    begin op_a = to_word(cfg_i.mass);     op_b = vv_q;                    end
      ST_XX:    begin op_a = pos_q;                   op_b = pos_q;                   end
      ST_E2:    begin op_a = to_word(cfg_i.stiffness); op_b = tmp_q;                  end
      ST_TRAP:  begin op_a = tsum_q;                  op_b = to_word(cfg_i.time_step); end
      ST_CV:    begin op_a = to_word(cfg_i.damping);  op_b = vel_q;                   end
      ST_KX:    begin op_a = to_word(cfg_i.stiffness); op_b = pos_q;                  end
      ST_ACC:   begin op_a = tmp_q;                   op_b = to_word(cfg_i.inv_mass); end
      ST_DV:    begin op_a = to_word(cfg_i.time_step); op_b = tmp_q;                  end
      ST_DX:    begin op_a = to_word(cfg_i.time_step); op_b = vel_q;                  end
      default:  begin op_a = '0;                      op_b = '0;                      end
    endcase
  end

  assign mul_req_o.start = mul_start;
  assign mul_req_o.op_a  = op_a;
  assign mul_req_o.op_b  = op_b;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    pos_d       = pos_q;
    vel_d       = vel_q;
    prev_d      = prev_q;
    work_d      = work_q;
    first_d     = first_q;
    f_d         = f_q;
    vv_d        = vv_q;
    pin_d       = pin_q;
    plost_d     = plost_q;
    ehalf_d     = ehalf_q;
    energy_d    = energy_q;
    net_d       = net_q;
    tsum_d      = tsum_q;
    resid_d     = resid_q;
    tmp_d       = tmp_q;
    npos_d      = npos_q;
    nvel_d      = nvel_q;
    o_pos_d     = o_pos_q;
    o_vel_d     = o_vel_q;
    o_pin_d     = o_pin_q;
    o_plost_d   = o_plost_q;
    o_energy_d  = o_energy_q;
    o_resid_d   = o_resid_q;

    // Result beat taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          f_d = force_req_i;
          // Restart clears the motion and the work sum before the step
          if (restart_i) begin
            pos_d   = '0;
            vel_d   = '0;
            work_d  = '0;
            first_d = 1'b1;
          end
          step_d  = ST_VV;
          state_d = S_ISSUE;
        end
      end

      S_ISSUE: begin
        case (step_q)
          ST_TSUM: begin
            tsum_d = sat_add(prev_q, net_q);
            step_d = ST_TRAP;
          end
          ST_TRAP: begin
            // No trapezoid on the first sample
            if (first_q) begin
              step_d = ST_RESID;
            end else begin
              mul_start = 1'b1;
              state_d   = S_WAIT;
            end
          end
          ST_RESID: begin
            resid_d = sat_sub(energy_q, work_q);
            prev_d  = net_q;
            first_d = 1'b0;
            step_d  = ST_CV;
          end
          default: begin
            mul_start = 1'b1;
            state_d   = S_WAIT;
          end
        endcase
      end

      S_WAIT: begin
        if (mul_done_i) begin
          state_d = S_ISSUE;
          case (step_q)
            ST_VV: begin
              vv_d   = mul_prod_i;
              step_d = ST_PIN;
            end
            ST_PIN: begin
              pin_d  = mul_prod_i;
              step_d = ST_PLOST;
            end
            ST_PLOST: begin
              plost_d = mul_prod_i;
              net_d   = sat_sub(pin_q, mul_prod_i);
              step_d  = ST_E1;
            end
            ST_E1: begin
              ehalf_d = halve(mul_prod_i);
              step_d  = ST_XX;
            end
            ST_XX: begin
              tmp_d  = mul_prod_i;
              step_d = ST_E2;
            end
            ST_E2: begin
              energy_d = sat_add(ehalf_q, halve(mul_prod_i));
              step_d   = ST_TSUM;
            end
            ST_TRAP: begin
              work_d = sat_add(work_q, halve(mul_prod_i));
              step_d = ST_RESID;
            end
            ST_CV: begin
              tmp_d  = sat_sub(f_q, mul_prod_i);
              step_d = ST_KX;
            end
            ST_KX: begin
              tmp_d  = sat_sub(tmp_q, mul_prod_i);
              step_d = ST_ACC;
            end
            ST_ACC: begin
              tmp_d  = mul_prod_i;
              step_d = ST_DV;
            end
            ST_DV: begin
              nvel_d = sat_add(vel_q, mul_prod_i);
              step_d = ST_DX;
            end
            ST_DX: begin
              npos_d  = sat_add(pos_q, mul_prod_i);
              state_d = S_WRITE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_WRITE: begin
        // Hand over the result beat and commit the Euler step
        if (!out_valid_q || !out_stall_i) begin
          o_pos_d     = pos_q;
          o_vel_d     = vel_q;
          o_pin_d     = pin_q;
          o_plost_d   = plost_q;
          o_energy_d  = energy_q;
          o_resid_d   = resid_q;
          out_valid_d = 1'b1;
          pos_d       = npos_q;
          vel_d       = nvel_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_VV;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      vel_q       <= '0;
      prev_q      <= '0;
      work_q      <= '0;
      first_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      prev_q      <= prev_d;
      work_q      <= work_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    vv_q       <= vv_d;
    pin_q      <= pin_d;
    plost_q    <= plost_d;
    ehalf_q    <= ehalf_d;
    energy_q   <= energy_d;
    net_q      <= net_d;
    tsum_q     <= tsum_d;
    resid_q    <= resid_d;
    tmp_q      <= tmp_d;
    npos_q     <= npos_d;
    nvel_q     <= nvel_d;
    o_pos_q    <= o_pos_d;
    o_vel_q    <= o_vel_d;
    o_pin_q    <= o_pin_d;
    o_plost_q  <= o_plost_d;
    o_energy_q <= o_energy_d;
    o_resid_q  <= o_resid_d;
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign position_o         = o_pos_q;
  assign velocity_o         = o_vel_q;
  assign power_in_o         = o_pin_q;
  assign power_lost_o       = o_plost_q;
  assign stored_energy_o    = o_energy_q;
  assign balance_residual_o = o_resid_q;

endmodule

`default_nettype wire

// File: rtl/mass_spring_damper_energy_step.sv
// ----------------------------------------------------------------------------
// mass_spring_damper_energy_step
// Forward-Euler mass-spring-damper with an energy-balance audit, Q16.32.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o    force_req_i, restart_i
//   out       output     out_valid_o / out_stall_i  position_o .. balance_residual_o
//   cfg       input      cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// A force beat is taken only while the block is idle, after the previous beat has been
// committed; a first sample skips the trapezoid product. Each beat runs twelve
// products on the shared 24x24 multiplier, two add steps and the commit. Reset
// (async, active low) restores the register defaults and clears position,
// velocity and work. A stalled result waits in the output register; only the
// commit of the next result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module mass_spring_damper_energy_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msd_pkg::CfgIdxBits-1:0]  cfg_addr_i,
  input  logic [msd_pkg::RegBits-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  msd_pkg::word_t                  force_req_i,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output msd_pkg::word_t                  position_o,
  output msd_pkg::word_t                  velocity_o,
  output msd_pkg::word_t                  power_in_o,
  output msd_pkg::word_t                  power_lost_o,
  output msd_pkg::word_t                  stored_energy_o,
  output msd_pkg::word_t                  balance_residual_o
);
  import msd_pkg::*;

  cfg_t     cfg;
  mul_req_t mul_req;
  logic     mul_done;
  word_t    mul_prod;

  // Configuration registers
  msd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Shared multiplier
  msd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Sequencer and datapath
  msd_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .force_req_i        (force_req_i),
    .restart_i          (restart_i),
    .cfg_i              (cfg),
    .mul_req_o          (mul_req),
    .mul_done_i         (mul_done),
    .mul_prod_i         (mul_prod),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .position_o         (position_o),
    .velocity_o         (velocity_o),
    .power_in_o         (power_in_o),
    .power_lost_o       (power_lost_o),
    .stored_energy_o    (stored_energy_o),
    .balance_residual_o (balance_residual_o)
  );

endmodule

`default_nettype wire

// File: rtl/msd_chk.sv
// ----------------------------------------------------------------------------
// msd_chk
// Port-level checks for the mass-spring-damper energy step block, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input msd_pkg::word_t                  force_req_i,
  input logic                            restart_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input msd_pkg::word_t                  position_o,
  input msd_pkg::word_t                  velocity_o,
  input msd_pkg::word_t                  power_in_o,
  input msd_pkg::word_t                  power_lost_o,
  input msd_pkg::word_t                  stored_energy_o,
  input msd_pkg::word_t                  balance_residual_o
);
  import msd_pkg::*;

  // A stalled result beat stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o) &&
      $stable(velocity_o) && $stable(power_in_o) && $stable(power_lost_o) &&
      $stable(stored_energy_o) && $stable(balance_residual_o))
    else $error("stalled result beat changed");

  // A stalled force beat stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(force_req_i) &&
      $stable(restart_i))
    else $error("stalled force beat changed");

  // An accepted force beat keeps the block busy for the multiply sequence
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("block free too soon after accepting a beat");

  // A new result appears only as the block finishes its step
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result delivered while block still busy");

  // An idle block with an empty output register produces nothing next cycle
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result beat without a finished step");

endmodule

bind mass_spring_damper_energy_step msd_chk u_msd_chk (.*);

`default_nettype wire

// File: verif/mass_spring_damper_energy_step_tb.sv
// ----------------------------------------------------------------------------
// mass_spring_damper_energy_step_tb
// Self-checking bench for the forward-Euler oscillator with energy audit.
// A short table of force beats runs first, then random beats under a series
// of register profiles (defaults, all zero, all ones, wide random, plausible
// physics). Every result beat is checked field by field against an in-bench
// fixed-point model of the oscillator or, for typed rows, the typed-in values.
// ----------------------------------------------------------------------------

module mass_spring_damper_energy_step_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  // Spare register indexes, outside the map; writes to them must be ignored
  localparam logic [CfgIdxBits-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegSpareHi = 3'd7;

  localparam int NumPhases      = 10;
  localparam int BeatsPerPhase  = 95;
  localparam int NumTableRows   = 20;
  localparam int DrainLimit     = 50000;
  localparam int SettleCycles   = 150;

  // One result beat, fields in port order
  typedef struct packed {
    word_t position;
    word_t velocity;
    word_t power_in;
    word_t power_lost;
    word_t stored_energy;
    word_t balance_residual;
  } sample_t;

  typedef struct {
    word_t   force_val;
    bit      restart;
    bit      typed;
    sample_t want;
  } stim_row_t;

  typedef enum {
    PROF_DEFAULT,
    PROF_ZERO,
    PROF_FULL,
    PROF_WIDE,
    PROF_PLAUSIBLE
  } cfg_profile_e;

  typedef enum {
    STALL_NONE,
    STALL_COIN,
    STALL_LONG,
    STALL_SPARSE
  } stall_mode_e;

  // DUT ports
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgIdxBits-1:0] cfg_addr_i = '0;
  logic [RegBits-1:0]    cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  word_t           force_req_i = '0;
  logic            restart_i   = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  word_t           position_o;
  word_t           velocity_o;
  word_t           power_in_o;
  word_t           power_lost_o;
  word_t           stored_energy_o;
  word_t           balance_residual_o;

  // Model state and register copies
  longint osc_pos, osc_vel, osc_prev_net, osc_work;
  bit     osc_first;
  longint k_mass, k_inv_mass, k_damping, k_stiffness, k_dt;

  sample_t predicted_samples [$];
  int      fault_count = 0;
  int      burst_left  = 0;
  bit      gapless     = 1'b0;

  string field_names [6] = '{"position", "velocity", "power_in", "power_lost",
                             "stored_energy", "balance_residual"};

  // Directed beats; all-zero results typed in where state is known to be clear
  stim_row_t table_rows [NumTableRows] = '{
    '{'0,                        1'b0, 1'b1, '0},  // first beat after reset
    '{WordMax,                   1'b0, 1'b0, '0},
    '{WordMax,                   1'b0, 1'b0, '0},
    '{WordMax,                   1'b0, 1'b0, '0},
    '{WordMin,                   1'b0, 1'b0, '0},
    '{word_t'(-1),               1'b0, 1'b0, '0},
    '{word_t'(1),                1'b0, 1'b0, '0},
    '{'0,                        1'b0, 1'b0, '0},
    '{'0,                        1'b1, 1'b1, '0},  // restart clears everything
    '{WordMin,                   1'b1, 1'b1, '0},  // restart twice in a row
    '{WordMin,                   1'b0, 1'b0, '0},
    '{WordMin,                   1'b0, 1'b0, '0},
    '{word_t'(48'h1_0000_0000),  1'b0, 1'b0, '0},
    '{word_t'(48'h5555_5555_5555), 1'b0, 1'b0, '0},
    '{word_t'(48'hAAAA_AAAA_AAAA), 1'b0, 1'b0, '0},
    '{WordMax,                   1'b0, 1'b0, '0},
    '{'0,                        1'b0, 1'b0, '0},
    '{WordMax,                   1'b1, 1'b1, '0},  // restart under full force
    '{word_t'(-48'sd4294967296), 1'b0, 1'b0, '0},
    '{'0,                        1'b0, 1'b0, '0}
  };

  cfg_profile_e phase_plan [NumPhases] = '{
    PROF_PLAUSIBLE, PROF_FULL, PROF_WIDE, PROF_PLAUSIBLE, PROF_ZERO,
    PROF_DEFAULT, PROF_PLAUSIBLE, PROF_WIDE, PROF_FULL, PROF_PLAUSIBLE
  };

  mass_spring_damper_energy_step i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .force_req_i        (force_req_i),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .position_o         (position_o),
    .velocity_o         (velocity_o),
    .power_in_o         (power_in_o),
    .power_lost_o       (power_lost_o),
    .stored_energy_o    (stored_energy_o),
    .balance_residual_o (balance_residual_o)
  );

  always #5 clk_i = ~clk_i;

  // ---- fixed-point arithmetic of the model --------------------------------

  function automatic longint clamp_word(longint a);
    if (a > longint'(WordMax)) return longint'(WordMax);
    if (a < longint'(WordMin)) return longint'(WordMin);
    return a;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  // Exact product, magnitude truncated by the fraction bits, then clamped
  function automatic longint fx_mul(longint a, longint b);
    logic [WordBits-1:0]   ma, mb;
    logic [2*WordBits-1:0] prod;
    logic [63:0]           mag;
    bit                    neg;
    neg  = (a < 0) != (b < 0);
    ma   = WordBits'((a < 0) ? -a : a);
    mb   = WordBits'((b < 0) ? -b : b);
    prod = {{WordBits{1'b0}}, ma} * {{WordBits{1'b0}}, mb};
    mag  = prod[2*WordBits-1:FracBits];
    if (mag > 64'(longint'(WordMax))) return neg ? longint'(WordMin) : longint'(WordMax);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // One oscillator step: report the state, audit energy, then integrate
  function automatic sample_t advance_oscillator(word_t force_val, bit restart);
    longint  f, x, v, vv, pin, plost, energy, net, acc;
    sample_t r;
    f = longint'(force_val);
    if (restart) begin
      osc_pos   = 0;
      osc_vel   = 0;
      osc_work  = 0;
      osc_first = 1'b1;
    end
    x      = osc_pos;
    v      = osc_vel;
    vv     = fx_mul(v, v);
    pin    = fx_mul(f, v);
    plost  = fx_mul(k_damping, vv);
    energy = fx_add(fx_mul(k_mass, vv) / 2, fx_mul(k_stiffness, fx_mul(x, x)) / 2);
    net    = fx_sub(pin, plost);
    // trapezoid; the very first beat after a clear adds nothing
    if (!osc_first) begin
      osc_work = fx_add(osc_work, fx_mul(fx_add(osc_prev_net, net), k_dt) / 2);
    end
    osc_prev_net = net;
    osc_first    = 1'b0;

    r.position         = word_t'(x);
    r.velocity         = word_t'(v);
    r.power_in         = word_t'(pin);
    r.power_lost       = word_t'(plost);
    r.stored_energy    = word_t'(energy);
    r.balance_residual = word_t'(fx_sub(energy, osc_work));

    // forward Euler; position uses the old velocity
    acc     = fx_mul(fx_sub(fx_sub(f, fx_mul(k_damping, v)), fx_mul(k_stiffness, x)),
                     k_inv_mass);
    osc_vel = fx_add(v, fx_mul(k_dt, acc));
    osc_pos = fx_add(x, fx_mul(k_dt, v));
    return r;
  endfunction

  // ---- stimulus helpers -----------------------------------------------------

  // Called just after a falling edge; leaves the write enable high
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, creg_t val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_MASS:      k_mass      = longint'(val);
      REG_INV_MASS:  k_inv_mass  = longint'(val);
      REG_DAMPING:   k_damping   = longint'(val);
      REG_STIFFNESS: k_stiffness = longint'(val);
      REG_TIME_STEP: k_dt        = longint'(val);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_profile(cfg_profile_e prof);
    creg_t m, im, c, k, dt;
    case (prof)
      PROF_DEFAULT: begin
        m = MassRst; im = InvMassRst; c = DampingRst; k = StiffnessRst; dt = TimeStepRst;
      end
      PROF_ZERO: begin
        m = '0; im = '0; c = '0; k = '0; dt = '0;
      end
      PROF_FULL: begin
        m = '1; im = '1; c = '1; k = '1; dt = '1;
      end
      PROF_WIDE: begin
        m  = creg_t'({$urandom, $urandom});
        im = creg_t'({$urandom, $urandom});
        c  = creg_t'({$urandom, $urandom});
        k  = creg_t'({$urandom, $urandom});
        dt = creg_t'({$urandom, $urandom});
      end
      default: begin
        // masses 0.125..2, inverse 1/16..4, modest damping and stiffness
        m  = creg_t'($urandom_range(1, 16)) << 29;
        im = creg_t'($urandom_range(1, 64)) << 28;
        c  = creg_t'($urandom) << $urandom_range(0, 3);
        k  = creg_t'($urandom) << $urandom_range(0, 8);
        dt = creg_t'($urandom_range(1, 1 << 24)) << $urandom_range(0, 4);
      end
    endcase
    write_reg(REG_MASS, m);
    write_reg(REG_INV_MASS, im);
    write_reg(REG_DAMPING, c);
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_TIME_STEP, dt);
    write_reg(3'($urandom_range(RegSpareLo, RegSpareHi)), creg_t'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one force beat in bursts, with random gaps unless gapless; model it on acceptance
  task automatic feed_beat(word_t force_val, bit restart, bit typed, sample_t want);
    sample_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!gapless) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    force_req_i <= force_val;
    restart_i   <= restart;
    do @(posedge clk_i); while (in_stall_o);
    pred = advance_oscillator(force_val, restart);
    predicted_samples.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  // Idle until every predicted beat has come back
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (predicted_samples.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (predicted_samples.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, predicted_samples.size());
      fault_count += predicted_samples.size();
      predicted_samples.delete();
    end
    repeat (8) @(negedge clk_i);
  endtask

  function automatic word_t pick_force();
    case ($urandom_range(0, 9))
      0, 1, 2: return word_t'({$urandom, $urandom});
      3, 4, 5, 6: return word_t'(longint'(int'($urandom)) <<< $urandom_range(0, 15));
      7: return WordMax;
      8: return WordMin;
      default: return word_t'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  // ---- receiver stall pattern -------------------------------------------------

  stall_mode_e stall_mode  = STALL_NONE;
  int          stall_ticks = 0;

  always @(negedge clk_i) begin
    stall_ticks++;
    if (stall_ticks % 300 == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_COIN:   out_stall_i <= 1'($urandom_range(0, 1));
      STALL_LONG:   out_stall_i <= (stall_ticks % 40) < 25;
      default:      out_stall_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---- result checker --------------------------------------------------------

  always @(posedge clk_i) begin
    sample_t got, want;
    logic [6*WordBits-1:0] gv, wv;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      got = '{position_o, velocity_o, power_in_o, power_lost_o,
              stored_energy_o, balance_residual_o};
      if (predicted_samples.size() == 0) begin
        $display("%0t: unexpected result beat, position %0d", $time, position_o);
        fault_count++;
      end else begin
        want = predicted_samples.pop_front();
        gv   = got;
        wv   = want;
        for (int i = 0; i < 6; i++) begin
          if (gv[(5-i)*WordBits +: WordBits] !== wv[(5-i)*WordBits +: WordBits]) begin
            $display("%0t: %s expected %0d got %0d", $time, field_names[i],
                     $signed(wv[(5-i)*WordBits +: WordBits]),
                     $signed(gv[(5-i)*WordBits +: WordBits]));
            fault_count++;
          end
        end
      end
    end
  end

  // ---- main sequence ---------------------------------------------------------

  initial begin
    k_mass       = longint'(MassRst);
    k_inv_mass   = longint'(InvMassRst);
    k_damping    = longint'(DampingRst);
    k_stiffness  = longint'(StiffnessRst);
    k_dt         = longint'(TimeStepRst);
    osc_pos      = 0;
    osc_vel      = 0;
    osc_prev_net = 0;
    osc_work     = 0;
    osc_first    = 1'b1;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // table of directed beats under the reset defaults
    foreach (table_rows[i]) begin
      feed_beat(table_rows[i].force_val, table_rows[i].restart,
                table_rows[i].typed, table_rows[i].want);
    end
    drain_results();

    // random beats, one register profile per phase
    foreach (phase_plan[p]) begin
      program_profile(phase_plan[p]);
      gapless    = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      repeat (BeatsPerPhase) begin
        feed_beat(pick_force(), $urandom_range(0, 19) == 0, 1'b0, '0);
      end
      drain_results();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("mass_spring_damper_energy_step_tb passed");
    end else begin
      $display("mass_spring_damper_energy_step_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("mass_spring_damper_energy_step_tb failed");
    $finish;
  end

endmodule
